@@ rtl/core/pda_pkg.sv @@
// ----------------------------------------------------------------------------
// Packed decimal ALU package
// Shared types, command codes and the divide-by-ten helper.
// ----------------------------------------------------------------------------
package pda_pkg;

    typedef enum logic [1:0] {
        CMD_ADD       = 2'd0,
        CMD_SUB       = 2'd1,
        CMD_TO_ZONED  = 2'd2,
        CMD_TO_PACKED = 2'd3
    } command_t;

    localparam logic [7:0] DEC_MODULUS = 8'd100;
    localparam logic [3:0] DIGIT_MAX   = 4'd9;
    localparam logic [7:0] RECIP_TEN   = 8'd205;

    typedef struct packed {
        command_t    command;
        logic [15:0] source_operand;
        logic [7:0]  dest_operand;
        logic [7:0]  zone_pattern;
        logic        carry_in;
        logic        zero_in;
    } cmd_t;

    typedef struct packed {
        logic [15:0] result_value;
        logic        carry_out;
        logic        zero_out;
        logic        decimal_error;
    } result_t;

    typedef struct packed {
        logic [3:0] quot;
        logic [3:0] rem;
    } digits_t;

    // Converts a two-nibble byte to hi*10+lo, with nibbles taken at face value.
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        bcd_to_bin = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
    endfunction

    // Splits a value below 160 into tens and units by a reciprocal multiply.
    function automatic digits_t div_ten(input logic [7:0] x);
        logic [15:0] prod;
        logic [3:0]  q;
        logic [7:0]  qx10;
        prod = x * RECIP_TEN;
        q    = prod[14:11];
        qx10 = {1'b0, q, 3'b000} + {3'b000, q, 1'b0};
        div_ten.quot = q;
        div_ten.rem  = 4'(x - qx10);
    endfunction

endpackage

@@ rtl/core/pda_if.sv @@
// ----------------------------------------------------------------------------
// Packed decimal ALU channel interfaces
// Command and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pda_cmd_if;
    import pda_pkg::*;

    logic        valid;
    logic        ready;
    command_t    command;
    logic [15:0] source_operand;
    logic [7:0]  dest_operand;
    logic [7:0]  zone_pattern;
    logic        carry_in;
    logic        zero_in;

    modport source (
        output valid, command, source_operand, dest_operand, zone_pattern,
               carry_in, zero_in,
        input  ready
    );

    modport sink (
        input  valid, command, source_operand, dest_operand, zone_pattern,
               carry_in, zero_in,
        output ready
    );
endinterface

interface pda_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_value;
    logic        carry_out;
    logic        zero_out;
    logic        decimal_error;

    modport source (
        output valid, result_value, carry_out, zero_out, decimal_error,
        input  ready
    );

    modport sink (
        input  valid, result_value, carry_out, zero_out, decimal_error,
        output ready
    );
endinterface

@@ rtl/core/pda_alu.sv @@
// ----------------------------------------------------------------------------
// Packed decimal ALU datapath
// Decimal add and subtract, packed/zoned conversion and flag generation.
// ----------------------------------------------------------------------------
module pda_alu
    import pda_pkg::*;
(
    input  cmd_t    op,
    output result_t result
);

    logic [7:0] dest_bin;
    logic [7:0] src_bin;
    logic [7:0] add_raw;
    logic       add_carry;
    logic [7:0] add_val;
    logic [7:0] sub_raw;
    logic       sub_borrow;
    logic [7:0] sub_val;
    logic       sub_neg;
    logic [7:0] sub_mag;
    logic [7:0] div_in;
    digits_t    dig;
    logic [7:0] q_signed;
    logic [7:0] r_signed;
    logic [7:0] packed_src;
    logic [7:0] joined;
    logic [3:0] zone_hi;
    logic       zone_bad;
    logic       digit_bad;

    assign dest_bin = bcd_to_bin(op.dest_operand);
    assign src_bin  = bcd_to_bin(op.source_operand[7:0]);

    assign add_raw   = dest_bin + src_bin + {7'd0, op.carry_in};
    assign add_carry = (add_raw >= DEC_MODULUS);
    assign add_val   = add_carry ? (add_raw - DEC_MODULUS) : add_raw;

    assign sub_raw    = dest_bin - src_bin - {7'd0, op.carry_in};
    assign sub_borrow = sub_raw[7];
    assign sub_val    = sub_borrow ? (sub_raw + DEC_MODULUS) : sub_raw;
    assign sub_neg    = sub_val[7];
    assign sub_mag    = sub_neg ? (8'd0 - sub_val) : sub_val;

    assign div_in = (op.command == CMD_ADD) ? add_val : sub_mag;
    assign dig    = div_ten(div_in);

    // Truncated signed quotient and remainder for a negative difference.
    assign q_signed = sub_neg ? (8'd0 - {4'd0, dig.quot}) : {4'd0, dig.quot};
    assign r_signed = sub_neg ? (8'd0 - {4'd0, dig.rem}) : {4'd0, dig.rem};

    assign packed_src = op.source_operand[7:0];
    assign joined     = {op.source_operand[3:0], op.source_operand[11:8]};
    assign zone_hi    = op.zone_pattern[7:4];
    assign zone_bad   = (op.source_operand[7:4] != zone_hi)
                     || (op.source_operand[15:12] != zone_hi);
    assign digit_bad  = (op.source_operand[3:0] > DIGIT_MAX)
                     || (op.source_operand[11:8] > DIGIT_MAX);

    always_comb
    begin
        result = '0;
        result.carry_out = op.carry_in;
        result.zero_out  = op.zero_in;
        unique case (op.command)
            CMD_ADD:
            begin
                result.result_value = {8'd0, dig.quot, dig.rem};
                result.carry_out    = add_carry;
                if ((add_val != 8'd0) || add_carry)
                begin
                    result.zero_out = 1'b0;
                end
            end
            CMD_SUB:
            begin
                result.result_value = {8'd0, {q_signed[3:0], 4'd0} | r_signed};
                result.carry_out    = sub_borrow;
                if ((sub_val != 8'd0) || sub_borrow)
                begin
                    result.zero_out = 1'b0;
                end
            end
            CMD_TO_ZONED:
            begin
                result.result_value = {4'd0, packed_src[3:0], 4'd0, packed_src[7:4]}
                                    | {op.zone_pattern, op.zone_pattern};
                if (packed_src != 8'd0)
                begin
                    result.zero_out = 1'b0;
                end
            end
            CMD_TO_PACKED:
            begin
                result.result_value  = {8'd0, joined};
                result.decimal_error = zone_bad || digit_bad;
                if (joined != 8'd0)
                begin
                    result.zero_out = 1'b0;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

@@ rtl/core/packed_decimal_alu_unit.sv @@
// ----------------------------------------------------------------------------
// Packed decimal ALU unit
// Decimal add/subtract and packed/zoned conversion with flag outputs.
// ----------------------------------------------------------------------------
//  Channel   Direction   Contents
//  cmd       in          command, operands, zone pattern, carry and zero flags
//  res       out         result value, carry, zero and decimal error flags
//
//  Each transaction is captured in an input register, computed combinationally
//  and held in the result register.
//  A new command transaction is taken every cycle while results are drained.
//  A stalled result holds both stages; the input stage still fills if empty.
//  Reset clears only the two stage valid bits.
// ----------------------------------------------------------------------------
module packed_decimal_alu_unit
    import pda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pda_cmd_if.sink    cmd,
    pda_res_if.source  res
);

    logic    s1_valid_reg;
    logic    s1_valid_next;
    cmd_t    s1_reg;
    cmd_t    s1_in;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    result_t alu_result;
    logic    out_load;
    logic    accept;

    assign out_load = !out_valid_reg || res.ready;
    assign cmd.ready = !s1_valid_reg || out_load;
    assign accept = cmd.valid && cmd.ready;

    assign s1_in.command        = cmd.command;
    assign s1_in.source_operand = cmd.source_operand;
    assign s1_in.dest_operand   = cmd.dest_operand;
    assign s1_in.zone_pattern   = cmd.zone_pattern;
    assign s1_in.carry_in       = cmd.carry_in;
    assign s1_in.zero_in        = cmd.zero_in;

    pda_alu u_alu (
        .op     (s1_reg),
        .result (alu_result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_load ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_in;
        end
        if (out_load)
        begin
            out_reg <= alu_result;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.result_value  = out_reg.result_value;
    assign res.carry_out     = out_reg.carry_out;
    assign res.zero_out      = out_reg.zero_out;
    assign res.decimal_error = out_reg.decimal_error;

`ifndef SYNTHESIS
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (s1_valid_reg && out_valid_reg && !res.ready))
        else $error("Command channel stalled while a stage was free.");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_load) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("Input stage changed while the result stage was stalled.");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("Result became valid without a captured transaction.");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packed decimal ALU testbench
// Drives directed and random decimal commands through the command channel
// under several idle and stall mixes. Every result transaction is checked
// field by field against an in-order prediction of the decimal arithmetic.
// ----------------------------------------------------------------------------
import pda_pkg::*;

class decimal_scoreboard;
    result_t     expected_q[$];
    int unsigned mismatches;

    function new();
        mismatches = 0;
    endfunction

    task report(string msg);
        if (mismatches < 40)
            $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    function int packed_to_binary(logic [7:0] b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function result_t predict(cmd_t c);
        result_t    r;
        int         s;
        int         q;
        int         m;
        logic [7:0] w;
        r = '0;
        r.carry_out = c.carry_in;
        r.zero_out  = c.zero_in;
        case (c.command)
            CMD_ADD:
            begin
                s = (packed_to_binary(c.dest_operand)
                     + packed_to_binary(c.source_operand[7:0]) + int'(c.carry_in)) & 255;
                r.carry_out = (s >= 100);
                if (r.carry_out)
                    s = s - 100;
                if (s != 0 || r.carry_out)
                    r.zero_out = 1'b0;
                r.result_value = {8'h00, 4'(s / 10), 4'(s % 10)};
            end
            CMD_SUB:
            begin
                w = 8'(packed_to_binary(c.dest_operand)
                       - packed_to_binary(c.source_operand[7:0]) - int'(c.carry_in));
                s = $signed(w);
                r.carry_out = (s < 0);
                if (r.carry_out)
                    s = s + 100;
                if (s != 0 || r.carry_out)
                    r.zero_out = 1'b0;
                q = s / 10;
                m = s % 10;
                r.result_value = {8'h00, 8'((q * 16) | m)};
            end
            CMD_TO_ZONED:
            begin
                r.result_value = {4'h0, c.source_operand[3:0], 4'h0, c.source_operand[7:4]}
                                 | {c.zone_pattern, c.zone_pattern};
                if (c.source_operand[7:0] != 8'h00)
                    r.zero_out = 1'b0;
            end
            default:
            begin
                if (c.source_operand[7:4] != c.zone_pattern[7:4]
                    || c.source_operand[15:12] != c.zone_pattern[7:4]
                    || c.source_operand[3:0] > 4'd9 || c.source_operand[11:8] > 4'd9)
                    r.decimal_error = 1'b1;
                r.result_value = {8'h00, c.source_operand[3:0], c.source_operand[11:8]};
                if (r.result_value != 16'h0000)
                    r.zero_out = 1'b0;
            end
        endcase
        return r;
    endfunction

    function void note_command(cmd_t c);
        expected_q.push_back(predict(c));
    endfunction

    task check_result(result_t r);
        result_t e;
        if (expected_q.size() == 0)
        begin
            report($sformatf("result %h arrived with nothing expected", r));
            return;
        end
        e = expected_q.pop_front();
        if (r.result_value !== e.result_value)
            report($sformatf("result_value %h, expected %h", r.result_value, e.result_value));
        if (r.carry_out !== e.carry_out)
            report($sformatf("carry_out %b, expected %b", r.carry_out, e.carry_out));
        if (r.zero_out !== e.zero_out)
            report($sformatf("zero_out %b, expected %b", r.zero_out, e.zero_out));
        if (r.decimal_error !== e.decimal_error)
            report($sformatf("decimal_error %b, expected %b", r.decimal_error, e.decimal_error));
    endtask
endclass

module testbench;
    localparam int unsigned CYCLE_LIMIT = 250000;

    logic              clk = 1'b0;
    logic              rst_n;
    int unsigned       cycle_count = 0;
    int unsigned       sender_idle_pct;
    int unsigned       receiver_stall_pct;
    decimal_scoreboard sb;

    pda_cmd_if cmd_ch();
    pda_res_if res_ch();

    packed_decimal_alu_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            sb.check_result({res_ch.result_value, res_ch.carry_out, res_ch.zero_out,
                             res_ch.decimal_error});
        res_ch.ready <= (rst_n === 1'b1) && ($urandom_range(99) >= receiver_stall_pct);
    end

    function cmd_t make_command(command_t op, logic [15:0] src, logic [7:0] dst,
                                logic [7:0] zone, logic cy, logic z);
        cmd_t c;
        c.command        = op;
        c.source_operand = src;
        c.dest_operand   = dst;
        c.zone_pattern   = zone;
        c.carry_in       = cy;
        c.zero_in        = z;
        return c;
    endfunction

    function logic [7:0] random_bcd();
        return {4'($urandom_range(9)), 4'($urandom_range(9))};
    endfunction

    function cmd_t random_command();
        cmd_t       c;
        logic [3:0] zn;
        c = make_command(command_t'($urandom_range(3)), 16'($urandom), 8'($urandom),
                         8'($urandom), 1'($urandom), 1'($urandom));
        if ($urandom_range(99) < 65)
        begin
            zn = c.zone_pattern[7:4];
            case (c.command) inside
                CMD_ADD, CMD_SUB:
                begin
                    c.source_operand[7:0] = random_bcd();
                    c.dest_operand        = random_bcd();
                end
                CMD_TO_ZONED:
                    c.source_operand[7:0] = random_bcd();
                default:
                    c.source_operand = {zn, 4'($urandom_range(9)), zn, 4'($urandom_range(9))};
            endcase
        end
        return c;
    endfunction

    task send_command(cmd_t c);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.command        <= c.command;
        cmd_ch.source_operand <= c.source_operand;
        cmd_ch.dest_operand   <= c.dest_operand;
        cmd_ch.zone_pattern   <= c.zone_pattern;
        cmd_ch.carry_in       <= c.carry_in;
        cmd_ch.zero_in        <= c.zero_in;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        sb.note_command(c);
    endtask

    task wait_for_results();
        cmd_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb                 = new();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        rst_n                 <= 1'b0;
        cmd_ch.valid          <= 1'b0;
        cmd_ch.command        <= CMD_ADD;
        cmd_ch.source_operand <= '0;
        cmd_ch.dest_operand   <= '0;
        cmd_ch.zone_pattern   <= '0;
        cmd_ch.carry_in       <= 1'b0;
        cmd_ch.zero_in        <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(make_command(CMD_ADD, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b1));
        send_command(make_command(CMD_ADD, 16'h0099, 8'h99, 8'hFF, 1'b1, 1'b1));
        send_command(make_command(CMD_ADD, 16'h0001, 8'h99, 8'h00, 1'b0, 1'b1));
        send_command(make_command(CMD_ADD, 16'hFFFF, 8'hFF, 8'h00, 1'b1, 1'b0));
        send_command(make_command(CMD_ADD, 16'hAB0F, 8'hF0, 8'h5A, 1'b0, 1'b1));
        send_command(make_command(CMD_SUB, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b1));
        send_command(make_command(CMD_SUB, 16'h0001, 8'h00, 8'h00, 1'b0, 1'b1));
        send_command(make_command(CMD_SUB, 16'h0099, 8'h00, 8'hFF, 1'b1, 1'b0));
        send_command(make_command(CMD_SUB, 16'h00C8, 8'h00, 8'h00, 1'b0, 1'b1));
        send_command(make_command(CMD_SUB, 16'hFF00, 8'hFF, 8'h00, 1'b0, 1'b1));
        send_command(make_command(CMD_SUB, 16'h00FF, 8'h00, 8'h00, 1'b1, 1'b1));
        send_command(make_command(CMD_SUB, 16'h0042, 8'h42, 8'h00, 1'b0, 1'b1));
        send_command(make_command(CMD_TO_ZONED, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b1));
        send_command(make_command(CMD_TO_ZONED, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
        send_command(make_command(CMD_TO_ZONED, 16'hA559, 8'h00, 8'h30, 1'b0, 1'b1));
        send_command(make_command(CMD_TO_PACKED, 16'h3539, 8'h00, 8'h3F, 1'b0, 1'b1));
        send_command(make_command(CMD_TO_PACKED, 16'h0000, 8'h00, 8'h00, 1'b1, 1'b1));
        send_command(make_command(CMD_TO_PACKED, 16'h3539, 8'h00, 8'hF0, 1'b0, 1'b1));
        send_command(make_command(CMD_TO_PACKED, 16'hF3FA, 8'h00, 8'hF0, 1'b0, 1'b1));
        send_command(make_command(CMD_TO_PACKED, 16'hFFFF, 8'hFF, 8'hF0, 1'b1, 1'b0));
        send_command(make_command(CMD_TO_PACKED, 16'h3934, 8'h00, 8'h20, 1'b0, 1'b1));
        wait_for_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 52; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 52; end
                default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
            endcase
            repeat (470)
                send_command(random_command());
            wait_for_results();
        end

        receiver_stall_pct = 0;
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
